[src/sobel_charcoal_luma_filter_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the Sobel charcoal luma filter
// Concurrent checks on the block clock, off in synthesis.
// ----------------------------------------------------------------------------
`ifndef SOBEL_CHARCOAL_LUMA_FILTER_MACROS_SVH
`define SOBEL_CHARCOAL_LUMA_FILTER_MACROS_SVH
`ifndef SYNTHESIS
`define SCL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SCL_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define SCL_ASSERT(lbl, prop, msg)
`define SCL_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

[src/scl_pkg.sv]
// ----------------------------------------------------------------------------
// Sobel charcoal luma filter package
// Shared constants and types of the filter and its line store.
// ----------------------------------------------------------------------------
package scl_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int DIM_W      = 13;

  localparam logic [7:0] BORDER_LUMA = 8'd16;
  localparam int CLAMP_LO = 16;
  localparam int CLAMP_HI = 235;
  localparam int INVERT   = 251;
  localparam int MIX_ONE  = 256;

  localparam int SQ_W        = 21;
  localparam int SQRT_STEPS  = 11;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_EDGE_SCALE   = 3'd2,
    REG_MIX_LEVEL    = 3'd3,
    REG_ENABLE       = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0]       px;
    logic [COL_W-1:0] col;
    logic             no_out;
    logic             brd;
    logic             lc;
    logic             lr;
  } in_t;

  typedef struct packed {
    logic [7:0] mc;
    logic [2:0] cnt;
    logic       eofl;
    logic       fixv;
    logic [7:0] fixval;
  } side_t;

endpackage

[src/sobel_charcoal_luma_filter.sv]
// ----------------------------------------------------------------------------
// Sobel charcoal luma filter
// Edge magnitude of a 3x3 window, inverted and blended with the source.
// ----------------------------------------------------------------------------
// Pixels enter on the in channel in raster order, one beat per pixel, and
// results leave on the out channel with last_in_run and end_of_frame flags.
// Registers are to be written on the cfg channel while the block is idle; the
// block does not enforce this. Writing the frame width or height restarts the
// frame counters. Output row y is produced while input row y+1 arrives. With
// the filter enabled, an input normally gives one result beat; at the last
// column or on the last row it gives two, at both four, and an input on row 0
// or column 0 gives none. The first result beat of an input passes through the
// input register, which covers the line store read, then a gradient stage, a
// square stage, eleven stages of the square root, five stages of scaling and
// blending and the output register. Throughput is one pixel per cycle while
// the receiver takes every beat, reduced while one input emits several result
// beats; the output register sends those one per cycle as the receiver takes
// them. When the receiver stalls, the pipeline stages fill and in_ready_o
// drops once no stage is free. Reset clears counters, window and registers to
// their defaults; the line stores need no clearing.
// ----------------------------------------------------------------------------
`include "sobel_charcoal_luma_filter_macros.svh"

module sobel_charcoal_luma_filter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  luma_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  luma_out_o,
  output logic        last_in_run_o,
  output logic        end_of_frame_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i
);

  localparam int S_GRAD = 1;
  localparam int S_SQ   = 2;
  localparam int S_RT0  = 3;
  localparam int S_MAG  = S_RT0 + scl_pkg::SQRT_STEPS;
  localparam int S_E    = S_MAG + 1;
  localparam int S_V    = S_E + 1;
  localparam int S_P    = S_V + 1;
  localparam int S_RES  = S_P + 1;
  localparam int NST    = S_RES + 1;
  localparam int RT_W   = scl_pkg::SQ_W + 1;

  logic [scl_pkg::DIM_W-1:0] width_q, height_q;
  logic [9:0]                scale_q;
  logic [8:0]                mix_q;
  logic                      enable_q;
  logic                      cfg_fire, restart;

  logic [scl_pkg::COL_W-1:0] col_q;
  logic [scl_pkg::ROW_W-1:0] row_q;
  logic [scl_pkg::DIM_W-1:0] wc, hc;
  logic                      acc, lc_in, lr_in;

  logic [NST:0]   ld;
  logic [NST-1:0] vld_q;

  scl_pkg::in_t   s0_q;
  scl_pkg::side_t side_q [1:NST-1];
  scl_pkg::side_t side_d;

  logic [7:0] win_q [9];
  logic [7:0] win_d [9];
  logic [7:0] rd_up, rd_lo;
  logic       mv0;

  logic signed [10:0] pw [9];
  logic signed [10:0] gx, gy, ngx, ngy;
  logic [9:0]  ax_q, ay_q;
  logic [scl_pkg::SQ_W-1:0] sq_q;
  logic [RT_W-1:0] rem_q  [scl_pkg::SQRT_STEPS];
  logic [RT_W-1:0] root_q [scl_pkg::SQRT_STEPS];
  logic [11:0] mag_q;
  logic [13:0] e_q;
  logic [7:0]  v_q;
  logic [16:0] pa_q, pb_q;
  logic [7:0]  res_q;
  logic [13:0] cl;
  logic [8:0]  mcl;
  logic [17:0] psum;

  logic       busy_q, ld_e, last_beat;
  logic [2:0] cnt_q, idx_q;
  logic       eofl_q;
  logic [7:0] val_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign restart     = cfg_fire && (cfg_index_i == scl_pkg::REG_FRAME_WIDTH ||
                                    cfg_index_i == scl_pkg::REG_FRAME_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= scl_pkg::DIM_W'(720);
      height_q <= scl_pkg::DIM_W'(576);
      scale_q  <= 10'd384;
      mix_q    <= 9'd0;
      enable_q <= 1'b1;
    end else if (cfg_fire) begin
      unique case (cfg_index_i)
        scl_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_data_i;
        scl_pkg::REG_FRAME_HEIGHT: height_q <= cfg_data_i;
        scl_pkg::REG_EDGE_SCALE:   scale_q  <= cfg_data_i[9:0];
        scl_pkg::REG_MIX_LEVEL:    mix_q    <= cfg_data_i[8:0];
        scl_pkg::REG_ENABLE:       enable_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q < scl_pkg::DIM_W'(3)) begin
      wc = scl_pkg::DIM_W'(3);
    end else if (width_q > scl_pkg::DIM_W'(scl_pkg::MAX_WIDTH)) begin
      wc = scl_pkg::DIM_W'(scl_pkg::MAX_WIDTH);
    end else begin
      wc = width_q;
    end
    if (height_q < scl_pkg::DIM_W'(3)) begin
      hc = scl_pkg::DIM_W'(3);
    end else if (height_q > scl_pkg::DIM_W'(scl_pkg::MAX_HEIGHT)) begin
      hc = scl_pkg::DIM_W'(scl_pkg::MAX_HEIGHT);
    end else begin
      hc = height_q;
    end
  end

  assign acc   = in_valid_i && in_ready_o;
  assign lc_in = (scl_pkg::DIM_W'(col_q) + scl_pkg::DIM_W'(1)) >= wc;
  assign lr_in = (scl_pkg::DIM_W'(row_q) + scl_pkg::DIM_W'(1)) >= hc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (restart) begin
      col_q <= '0;
      row_q <= '0;
    end else if (acc) begin
      if (lc_in) begin
        col_q <= '0;
        row_q <= lr_in ? '0 : row_q + scl_pkg::ROW_W'(1);
      end else begin
        col_q <= col_q + scl_pkg::COL_W'(1);
      end
    end
  end

  always_comb begin
    ld[NST] = ld_e;
    for (int k = NST - 1; k >= 0; k--) begin
      ld[k] = !vld_q[k] || ld[k+1];
    end
  end
  assign in_ready_o = ld[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (ld[0]) begin
        vld_q[0] <= acc;
      end
      for (int k = 1; k < NST; k++) begin
        if (ld[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s0_q.px     <= luma_in_i;
      s0_q.col    <= col_q;
      s0_q.no_out <= (row_q == '0) || (col_q == '0);
      s0_q.brd    <= (row_q == scl_pkg::ROW_W'(1)) || (col_q == scl_pkg::COL_W'(1));
      s0_q.lc     <= lc_in;
      s0_q.lr     <= lr_in;
    end
  end

  assign mv0 = vld_q[0] && ld[S_GRAD];

  scl_line_store u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (acc),
    .rd_addr_i (col_q),
    .up_o      (rd_up),
    .lo_o      (rd_lo),
    .wr_en_i   (mv0),
    .wr_addr_i (s0_q.col),
    .wr_up_i   (rd_lo),
    .wr_lo_i   (s0_q.px)
  );

  always_comb begin
    win_d[0] = win_q[1];
    win_d[1] = win_q[2];
    win_d[2] = rd_up;
    win_d[3] = win_q[4];
    win_d[4] = win_q[5];
    win_d[5] = rd_lo;
    win_d[6] = win_q[7];
    win_d[7] = win_q[8];
    win_d[8] = s0_q.px;
    for (int i = 0; i < 9; i++) begin
      pw[i] = $signed({3'b000, win_d[i]});
    end
    gx  = (pw[2] - pw[0]) + ((pw[5] - pw[3]) <<< 1) + (pw[8] - pw[6]);
    gy  = (pw[6] - pw[0]) + ((pw[7] - pw[1]) <<< 1) + (pw[8] - pw[2]);
    ngx = -gx;
    ngy = -gy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= 8'd0;
      end
    end else if (mv0) begin
      win_q <= win_d;
    end
  end

  always_comb begin
    side_d.mc     = win_d[4];
    side_d.eofl   = s0_q.lc && s0_q.lr;
    side_d.fixval = scl_pkg::BORDER_LUMA;
    side_d.fixv   = s0_q.brd;
    side_d.cnt    = 3'd0;
    if (!enable_q) begin
      side_d.cnt    = 3'd1;
      side_d.fixv   = 1'b1;
      side_d.fixval = s0_q.px;
    end else if (!s0_q.no_out) begin
      side_d.cnt = 3'd1 + 3'(s0_q.lr) + 3'(s0_q.lc) + 3'(s0_q.lc && s0_q.lr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[S_GRAD]) begin
      side_q[S_GRAD] <= side_d;
      ax_q <= gx[10] ? ngx[9:0] : gx[9:0];
      ay_q <= gy[10] ? ngy[9:0] : gy[9:0];
    end
    for (int k = S_SQ; k < NST; k++) begin
      if (ld[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
    if (ld[S_SQ]) begin
      sq_q <= scl_pkg::SQ_W'(20'(ax_q) * 20'(ax_q)) + scl_pkg::SQ_W'(20'(ay_q) * 20'(ay_q));
    end
  end

  for (genvar j = 0; j < scl_pkg::SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [RT_W-1:0] BitJ = RT_W'(1) << (scl_pkg::SQ_W - 1 - 2 * j);
    logic [RT_W-1:0] rem_in, root_in, trial;
    if (j == 0) begin : g_first
      assign rem_in  = RT_W'(sq_q);
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
    end
    assign trial = root_in + BitJ;
    always_ff @(posedge clk_i) begin
      if (ld[S_RT0+j]) begin
        if (rem_in >= trial) begin
          rem_q[j]  <= rem_in - trial;
          root_q[j] <= (root_in >> 1) + BitJ;
        end else begin
          rem_q[j]  <= rem_in;
          root_q[j] <= root_in >> 1;
        end
      end
    end
  end

  always_comb begin
    if (e_q < 14'(scl_pkg::CLAMP_LO)) begin
      cl = 14'(scl_pkg::CLAMP_LO);
    end else if (e_q > 14'(scl_pkg::CLAMP_HI)) begin
      cl = 14'(scl_pkg::CLAMP_HI);
    end else begin
      cl = e_q;
    end
    mcl  = (mix_q > 9'(scl_pkg::MIX_ONE)) ? 9'(scl_pkg::MIX_ONE) : mix_q;
    psum = 18'(pa_q) + 18'(pb_q);
  end

  always_ff @(posedge clk_i) begin
    if (ld[S_MAG]) begin
      mag_q <= 12'((13'(root_q[scl_pkg::SQRT_STEPS-1][10:0]) * 13'd3) >> 1);
    end
    if (ld[S_E]) begin
      e_q <= 14'((22'(mag_q) * 22'(scale_q)) >> 8);
    end
    if (ld[S_V]) begin
      v_q <= 8'(14'(scl_pkg::INVERT) - cl);
    end
    if (ld[S_P]) begin
      pa_q <= 17'(9'(scl_pkg::MIX_ONE) - mcl) * 17'(v_q);
      pb_q <= 17'(mcl) * 17'(side_q[S_V].mc);
    end
    if (ld[S_RES]) begin
      res_q <= psum[15:8];
    end
  end

  assign last_beat = (idx_q == cnt_q - 3'd1);
  assign ld_e      = !busy_q || (out_ready_i && last_beat);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 3'd0;
    end else if (ld_e) begin
      busy_q <= vld_q[S_RES] && (side_q[S_RES].cnt != 3'd0);
      idx_q  <= 3'd0;
    end else if (out_ready_i) begin
      idx_q <= idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_e) begin
      cnt_q  <= side_q[S_RES].cnt;
      eofl_q <= side_q[S_RES].eofl;
      val_q  <= side_q[S_RES].fixv ? side_q[S_RES].fixval : res_q;
    end
  end

  assign out_valid_o    = busy_q;
  assign luma_out_o     = (idx_q == 3'd0) ? val_q : scl_pkg::BORDER_LUMA;
  assign last_in_run_o  = last_beat;
  assign end_of_frame_o = eofl_q && last_beat;

  `SCL_ASSERT(a_idx_in_run, !busy_q || (idx_q < cnt_q), "beat index beyond run length")
  `SCL_ASSERT(a_eof_is_last, !(out_valid_o && end_of_frame_o) || last_in_run_o,
              "end of frame on a beat that does not close its run")
  `SCL_ASSERT_NEXT(a_accept_fills, in_valid_i && in_ready_o, vld_q[0],
                   "accepted pixel missing from first stage")
  `SCL_ASSERT_NEXT(a_col_wrap, in_valid_i && in_ready_o && lc_in && !restart, col_q == '0,
                   "column counter did not wrap at end of row")

endmodule

[src/scl_line_store.sv]
// ----------------------------------------------------------------------------
// Line store
// Two row memories, read at the accepted column and written back later.
// ----------------------------------------------------------------------------
module scl_line_store (
  input  logic                      clk_i,
  input  logic                      rd_en_i,
  input  logic [scl_pkg::COL_W-1:0] rd_addr_i,
  output logic [7:0]                up_o,
  output logic [7:0]                lo_o,
  input  logic                      wr_en_i,
  input  logic [scl_pkg::COL_W-1:0] wr_addr_i,
  input  logic [7:0]                wr_up_i,
  input  logic [7:0]                wr_lo_i
);

  logic [7:0] upper_mem [scl_pkg::MAX_WIDTH];
  logic [7:0] lower_mem [scl_pkg::MAX_WIDTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      upper_mem[wr_addr_i] <= wr_up_i;
      lower_mem[wr_addr_i] <= wr_lo_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      up_o <= upper_mem[rd_addr_i];
      lo_o <= lower_mem[rd_addr_i];
    end
  end

endmodule

[bench/sobel_charcoal_luma_filter_test.sv]
// ----------------------------------------------------------------------------
// Sobel charcoal luma filter testbench
// Drives pixel frames under several register settings and checks every
// result beat against a cycle-free model of the filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sobel_charcoal_luma_filter_test;

  localparam logic [2:0] UNUSED_REG = 3'd7;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    bit [12:0] width;
    bit [12:0] height;
    bit [9:0]  scale;
    bit [8:0]  mix;
    bit        en;
  } setting_t;

  typedef struct {
    int       set_idx;
    bit [7:0] px;
    bit       chk;
    bit [7:0] luma;
  } stim_row_t;

  typedef struct {
    bit [7:0] luma;
    bit       last;
    bit       eof;
  } pixel_beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  luma_in_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  luma_out_o;
  logic        last_in_run_o;
  logic        end_of_frame_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [12:0] cfg_data_i;

  sobel_charcoal_luma_filter dut (.*);

  bit [12:0] m_width, m_height;
  bit [9:0]  m_scale;
  bit [8:0]  m_mix;
  bit        m_en;
  bit [7:0]  upper_line [scl_pkg::MAX_WIDTH];
  bit [7:0]  lower_line [scl_pkg::MAX_WIDTH];
  bit [7:0]  win [9];
  int unsigned col_pos, row_pos;

  pixel_beat_t pending_pixels[$];
  int  mismatches;
  bit  failed;
  bit  burst;

  setting_t  directed_sets [3];
  stim_row_t directed_rows [$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic int unsigned floor_sqrt(int unsigned v);
    int unsigned root;
    int unsigned b;
    root = 0;
    b = 1 << 30;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic bit [7:0] charcoal_pixel();
    int gx, gy;
    int unsigned mag, e, v, m;
    gx = (win[2] - win[0]) + 2 * (win[5] - win[3]) + (win[8] - win[6]);
    gy = (win[6] - win[0]) + 2 * (win[7] - win[1]) + (win[8] - win[2]);
    mag = 3 * floor_sqrt(gx * gx + gy * gy) / 2;
    e = (mag * m_scale) >> 8;
    if (e < scl_pkg::CLAMP_LO) e = scl_pkg::CLAMP_LO;
    if (e > scl_pkg::CLAMP_HI) e = scl_pkg::CLAMP_HI;
    v = scl_pkg::INVERT - e;
    m = (m_mix > scl_pkg::MIX_ONE) ? scl_pkg::MIX_ONE : m_mix;
    return 8'((((scl_pkg::MIX_ONE - m) * v) + m * win[4]) >> 8);
  endfunction

  function automatic void push_pixel(bit [7:0] luma, bit eof);
    pixel_beat_t b;
    b.luma = luma;
    b.last = 1'b0;
    b.eof = eof;
    pending_pixels.push_back(b);
  endfunction

  function automatic void predict_pixels(bit [7:0] px);
    int unsigned w, h, c, r;
    bit lc, lr;
    int n0;
    w = (m_width < 3) ? 3 :
        ((m_width > scl_pkg::MAX_WIDTH) ? scl_pkg::MAX_WIDTH : m_width);
    h = (m_height < 3) ? 3 :
        ((m_height > scl_pkg::MAX_HEIGHT) ? scl_pkg::MAX_HEIGHT : m_height);
    c = col_pos;
    r = row_pos;
    lc = (c + 1 >= w);
    lr = (r + 1 >= h);
    n0 = pending_pixels.size();
    if (c >= scl_pkg::MAX_WIDTH) c = scl_pkg::MAX_WIDTH - 1;
    win[0] = win[1]; win[1] = win[2];
    win[3] = win[4]; win[4] = win[5];
    win[6] = win[7]; win[7] = win[8];
    win[2] = upper_line[c];
    win[5] = lower_line[c];
    win[8] = px;
    upper_line[c] = lower_line[c];
    lower_line[c] = px;
    if (!m_en) begin
      push_pixel(px, lc && lr);
    end else if (r >= 1 && c >= 1) begin
      push_pixel((r == 1 || c == 1) ? scl_pkg::BORDER_LUMA : charcoal_pixel(), 1'b0);
      if (lr) push_pixel(scl_pkg::BORDER_LUMA, 1'b0);
      if (lc) begin
        push_pixel(scl_pkg::BORDER_LUMA, 1'b0);
        if (lr) push_pixel(scl_pkg::BORDER_LUMA, 1'b1);
      end
    end
    if (pending_pixels.size() > n0) pending_pixels[pending_pixels.size() - 1].last = 1'b1;
    if (lc) begin
      col_pos = 0;
      row_pos = lr ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  function automatic void apply_register(logic [2:0] idx, bit [12:0] data);
    case (idx)
      scl_pkg::REG_FRAME_WIDTH: begin
        m_width = data;
        col_pos = 0;
        row_pos = 0;
      end
      scl_pkg::REG_FRAME_HEIGHT: begin
        m_height = data;
        col_pos = 0;
        row_pos = 0;
      end
      scl_pkg::REG_EDGE_SCALE: m_scale = data[9:0];
      scl_pkg::REG_MIX_LEVEL: m_mix = data[8:0];
      scl_pkg::REG_ENABLE: m_en = data[0];
      default: ;
    endcase
  endfunction

  task automatic write_register(logic [2:0] idx, bit [12:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_register(idx, data);
  endtask

  task automatic load_setting(setting_t s);
    write_register(scl_pkg::REG_FRAME_WIDTH, s.width);
    write_register(scl_pkg::REG_FRAME_HEIGHT, s.height);
    write_register(scl_pkg::REG_EDGE_SCALE, 13'(s.scale));
    write_register(scl_pkg::REG_MIX_LEVEL, 13'(s.mix));
    write_register(scl_pkg::REG_ENABLE, 13'(s.en));
    if ($urandom_range(0, 3) == 0) write_register(UNUSED_REG, 13'($urandom_range(0, 8191)));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_until_idle();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_pixel(bit [7:0] px, bit chk, bit [7:0] luma);
    int gap;
    int n0;
    gap = burst ? 0 : $urandom_range(0, 10);
    if ($urandom_range(0, 31) == 0) burst = ~burst;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    luma_in_i <= px;
    do @(posedge clk_i); while (!in_ready_o);
    n0 = pending_pixels.size();
    predict_pixels(px);
    if (chk && pending_pixels.size() > n0) pending_pixels[n0].luma = luma;
  endtask

  function automatic bit [12:0] pick_dim(bit wide);
    int k;
    k = $urandom_range(0, 19);
    if (k == 0) return 13'd0;
    if (k == 1) return 13'd8191;
    if (k == 2 && wide) return 13'd4096;
    if (k == 3) return 13'($urandom_range(0, 8191));
    return 13'($urandom_range(3, wide ? 10 : 6));
  endfunction

  initial begin
    int sent;
    int cur;
    setting_t s;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    luma_in_i = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = scl_pkg::REG_FRAME_WIDTH;
    cfg_data_i = '0;
    m_width = 720;
    m_height = 576;
    m_scale = 384;
    m_mix = 0;
    m_en = 1'b1;
    col_pos = 0;
    row_pos = 0;
    foreach (win[i]) win[i] = '0;
    burst = 1'b0;
    directed_sets[0] = '{13'd3, 13'd3, 10'd1023, 9'd0, 1'b1};
    directed_sets[1] = '{13'd0, 13'd8191, 10'd0, 9'd256, 1'b0};
    directed_sets[2] = '{13'd4, 13'd4, 10'd512, 9'd256, 1'b1};
    directed_rows = '{
      '{0, 8'd0, 0, 8'd0}, '{0, 8'd0, 0, 8'd0}, '{0, 8'd0, 0, 8'd0},
      '{0, 8'd0, 0, 8'd0}, '{0, 8'd255, 1, 8'd16}, '{0, 8'd0, 1, 8'd16},
      '{0, 8'd255, 0, 8'd0}, '{0, 8'd255, 1, 8'd16}, '{0, 8'd255, 0, 8'd0},
      '{1, 8'd255, 1, 8'd255}, '{1, 8'd0, 1, 8'd0}, '{1, 8'd170, 1, 8'd170},
      '{1, 8'd85, 1, 8'd85},
      '{2, 8'd0, 0, 8'd0}, '{2, 8'd255, 0, 8'd0}, '{2, 8'd0, 0, 8'd0},
      '{2, 8'd255, 0, 8'd0}, '{2, 8'd255, 0, 8'd0}, '{2, 8'd0, 0, 8'd0},
      '{2, 8'd255, 0, 8'd0}, '{2, 8'd0, 0, 8'd0}, '{2, 8'd0, 0, 8'd0},
      '{2, 8'd255, 0, 8'd0}, '{2, 8'd0, 0, 8'd0}, '{2, 8'd255, 0, 8'd0}
    };
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cur = -1;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].set_idx != cur) begin
        wait_until_idle();
        cur = directed_rows[i].set_idx;
        load_setting(directed_sets[cur]);
      end
      send_pixel(directed_rows[i].px, directed_rows[i].chk, directed_rows[i].luma);
    end

    sent = 0;
    while (sent < 170) begin
      int n;
      wait_until_idle();
      s.width = pick_dim(1'b1);
      s.height = pick_dim(1'b0);
      case ($urandom_range(0, 4))
        0: s.scale = 10'd0;
        1: s.scale = 10'd1023;
        default: s.scale = 10'($urandom_range(0, 1023));
      endcase
      case ($urandom_range(0, 4))
        0: s.mix = 9'd0;
        1: s.mix = 9'd256;
        2: s.mix = 9'($urandom_range(257, 511));
        default: s.mix = 9'($urandom_range(0, 255));
      endcase
      s.en = ($urandom_range(0, 4) != 0);
      load_setting(s);
      n = $urandom_range(15, 45);
      repeat (n) send_pixel(8'($urandom_range(0, 255)), 1'b0, 8'd0);
      sent += n;
    end

    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (!failed) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    int stall;
    forever begin
      stall = burst ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i && rst_ni));
    end
  end

  always @(posedge clk_i) begin
    pixel_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_pixels.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: luma %0d", luma_out_o);
      end else begin
        want = pending_pixels.pop_front();
        if (luma_out_o !== want.luma || last_in_run_o !== want.last ||
            end_of_frame_o !== want.eof) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected luma %0d last %0b eof %0b, got %0d %0b %0b",
                     want.luma, want.last, want.eof,
                     luma_out_o, last_in_run_o, end_of_frame_o);
        end
      end
    end
  end

endmodule

[filelist.f]
+incdir+src
src/scl_pkg.sv
src/scl_line_store.sv
src/sobel_charcoal_luma_filter.sv
bench/sobel_charcoal_luma_filter_test.sv
